@@ hw/rtl/csfr_pkg.sv @@
`default_nettype none

package csfr_pkg;

    localparam int unsigned UNIT_COUNT = 10;
    localparam int unsigned IN_WIDTH   = 24;
    localparam int unsigned OUT_WIDTH  = 16;

    typedef logic [UNIT_COUNT-1:0] unit_mask_t;

    // Unit numbers, equal to the bit position in a mask.
    localparam int unsigned U_VF    = 0;
    localparam int unsigned U_DEPTH = 1;
    localparam int unsigned U_CONST = 2;
    localparam int unsigned U_DATA  = 3;
    localparam int unsigned U_TEX   = 4;
    localparam int unsigned U_RT    = 5;
    localparam int unsigned U_L3    = 6;
    localparam int unsigned U_MEM   = 7;
    localparam int unsigned U_CS    = 8;
    localparam int unsigned U_CPU   = 9;

    // Units at or below L3; vertex fetch joins the subtree on the newer hierarchy.
    localparam unit_mask_t L3_TREE_OLD = 10'b00_0111_1110;
    localparam unit_mask_t L3_TREE_NEW = 10'b00_0111_1111;

    localparam logic GEN_OLD = 1'b0;
    localparam logic GEN_NEW = 1'b1;

    // First member lands in the top bit, so vf_invalidate is bit 0.
    typedef struct packed {
        logic untyped_flush;
        logic hdc_flush;
        logic tile_flush;
        logic constant_invalidate;
        logic data_flush;
        logic color_flush;
        logic depth_flush;
        logic texture_invalidate;
        logic cmd_streamer_stall;
        logic vf_invalidate;
    } sync_flags_t;

    function automatic sync_flags_t resolve_flags(
        input logic       gen,
        input unit_mask_t src,
        input unit_mask_t dst
    );
        unit_mask_t  named;
        unit_mask_t  tree;
        logic        multi;
        logic        meet_mem;
        logic        l3_walk;
        logic        hdc_leaf;
        sync_flags_t f;
        named    = src | dst;
        tree     = (gen == GEN_NEW) ? L3_TREE_NEW : L3_TREE_OLD;
        // More than one distinct unit: common node is L3 or memory, never a leaf.
        multi    = (src != '0) && (dst != '0) && ((named & (named - unit_mask_t'(1))) != '0);
        meet_mem = multi && ((named & ~tree) != '0);
        // L3 lies on a writer path only when the meet is memory.
        l3_walk  = (gen == GEN_NEW) && meet_mem && ((src & L3_TREE_NEW) != '0);
        hdc_leaf = (gen == GEN_NEW) && multi && src[U_DATA];

        f = '0;
        f.vf_invalidate       = multi && dst[U_VF];
        f.cmd_streamer_stall  = multi && dst[U_CS];
        f.texture_invalidate  = multi && dst[U_TEX];
        f.constant_invalidate = multi && dst[U_CONST];
        f.depth_flush         = multi && src[U_DEPTH];
        f.color_flush         = multi && src[U_RT];
        f.hdc_flush           = hdc_leaf;
        f.tile_flush          = l3_walk && (f.depth_flush || f.color_flush);
        f.untyped_flush       = l3_walk && hdc_leaf;
        f.data_flush          = ((gen == GEN_OLD) && multi && src[U_DATA])
                                || (l3_walk && hdc_leaf);
        return f;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cache_sync_flush_resolver.sv @@
`default_nettype none

// Cache sync flush resolver. Each input transaction carries a writer mask and a
// reader mask over the ten cache units; the block returns one result transaction
// with the flush, invalidate and stall flags needed to make writer data visible
// to the readers. An empty mask on either side gives all-zero flags. One
// transaction can enter every cycle; each passes the input register, then the
// result register, and a stalled result register holds the pipe. cfg_we writes
// the hierarchy select (0 older, 1 newer); write it only while the block is idle.
module cache_sync_flush_resolver (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic                           cfg_wdata,      // generation_select
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [csfr_pkg::IN_WIDTH-1:0]  s_axis_tdata,   // src_units, dst_units, pad
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [csfr_pkg::OUT_WIDTH-1:0]      m_axis_tdata    // vf_invalidate,
                                                                // cmd_streamer_stall,
                                                                // texture_invalidate,
                                                                // depth_flush, color_flush,
                                                                // data_flush,
                                                                // constant_invalidate,
                                                                // tile_flush, hdc_flush,
                                                                // untyped_flush, pad
);
    import csfr_pkg::*;

    logic        gen_reg;
    logic        in_valid_reg;
    unit_mask_t  src_reg;
    unit_mask_t  dst_reg;
    logic        out_valid_reg;
    sync_flags_t out_reg;
    sync_flags_t out_next;
    logic        advance;

    // Stage 1 moves forward when the result register is empty or being drained.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign out_next      = resolve_flags(gen_reg, src_reg, dst_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg       <= GEN_OLD;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                gen_reg <= cfg_wdata;
            end
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            src_reg <= s_axis_tdata[UNIT_COUNT-1:0];
            dst_reg <= s_axis_tdata[2*UNIT_COUNT-1:UNIT_COUNT];
        end
        if (advance && in_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_WIDTH-UNIT_COUNT){1'b0}}, out_reg};

`ifndef SYNTHESIS
    a_empty_mask_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid_reg && (src_reg == '0 || dst_reg == '0))
        |=> (m_axis_tdata == '0))
        else $error("flags set for an empty mask");

    a_tile_needs_new_gen: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_reg.tile_flush) |-> (gen_reg == GEN_NEW))
        else $error("tile flush on older hierarchy");

    a_untyped_with_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_reg.untyped_flush)
        |-> (out_reg.data_flush && out_reg.hdc_flush))
        else $error("untyped flush without data and hdc flush");

    a_ready_when_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty result register");
`endif

endmodule

`default_nettype wire

@@ tb/tb_cache_sync_flush_resolver.sv @@
`timescale 1ns / 1ps

module tb_cache_sync_flush_resolver;

    import csfr_pkg::*;

    // Watchdog: cycles with no transaction on either side before the run is
    // called hung. The long output hold below is far shorter than this.
    localparam int unsigned IDLE_LIMIT  = 2000;
    localparam int unsigned LONG_HOLD   = 200;
    localparam int unsigned HOLD_AFTER  = 300;
    localparam int unsigned RANDOM_ITEMS = 430;
    // Two register stages in the block, plus a margin.
    localparam int unsigned DRAIN_CYCLES = 8;

    // Every block input has a known value from time zero.
    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic                 cfg_wdata     = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_WIDTH-1:0]  s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_WIDTH-1:0] m_axis_tdata;

    cache_sync_flush_resolver dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),      // generation_select
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // src_units, dst_units, pad
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // vf_invalidate, cmd_streamer_stall,
                                         // texture_invalidate, depth_flush,
                                         // color_flush, data_flush,
                                         // constant_invalidate, tile_flush, hdc_flush,
                                         // untyped_flush, pad
    );

    // Tracks the hierarchy select, predicts the flags of each accepted
    // request by walking the cache tree, and checks results in order.
    class sync_flag_tracker;
        logic          gen;
        sync_flags_t   pending_flags[$];
        int unsigned   mismatches;
        int unsigned   requests_noted;
        int unsigned   results_checked;

        function new();
            gen             = GEN_OLD;
            mismatches      = 0;
            requests_noted  = 0;
            results_checked = 0;
        endfunction

        // Memory is the root and is its own parent.
        function int unsigned parent_unit(int unsigned n);
            if (n == U_MEM || n == U_L3 || n == U_CS || n == U_CPU)
                return U_MEM;
            if (n == U_VF)
                return (gen == GEN_NEW) ? U_L3 : U_MEM;
            return U_L3;
        endfunction

        function int unsigned unit_level(int unsigned n);
            int unsigned lvl;
            lvl = 0;
            while (n != U_MEM) begin
                n = parent_unit(n);
                lvl++;
            end
            return lvl;
        endfunction

        function int unsigned meet_unit(int unsigned a, int unsigned b);
            while (unit_level(a) > unit_level(b))
                a = parent_unit(a);
            while (unit_level(b) > unit_level(a))
                b = parent_unit(b);
            while (a != b) begin
                a = parent_unit(a);
                b = parent_unit(b);
            end
            return a;
        endfunction

        // L3 on the newer tree flushes only what the flags so far call for.
        function void add_flush(int unsigned n, ref sync_flags_t f);
            case (n)
                U_DEPTH: f.depth_flush = 1'b1;
                U_RT:    f.color_flush = 1'b1;
                U_DATA:
                    if (gen == GEN_NEW)
                        f.hdc_flush = 1'b1;
                    else
                        f.data_flush = 1'b1;
                U_L3:
                    if (gen == GEN_NEW) begin
                        if (f.depth_flush || f.color_flush)
                            f.tile_flush = 1'b1;
                        if (f.hdc_flush) begin
                            f.data_flush    = 1'b1;
                            f.untyped_flush = 1'b1;
                        end
                    end
                default: ;
            endcase
        endfunction

        function void add_invalidate(int unsigned n, ref sync_flags_t f);
            case (n)
                U_VF:    f.vf_invalidate       = 1'b1;
                U_CONST: f.constant_invalidate = 1'b1;
                U_TEX:   f.texture_invalidate  = 1'b1;
                U_CS:    f.cmd_streamer_stall  = 1'b1;
                default: ;
            endcase
        endfunction

        function sync_flags_t predict_flags(unit_mask_t src, unit_mask_t dst);
            sync_flags_t f;
            unit_mask_t  named;
            int unsigned common;
            int unsigned n;
            bit          have;
            f     = '0;
            named = src | dst;
            have  = 0;
            common = U_MEM;
            if (src == '0 || dst == '0)
                return f;
            for (int unsigned i = 0; i < UNIT_COUNT; i++)
                if (named[i]) begin
                    common = have ? meet_unit(common, i) : i;
                    have   = 1;
                end
            // Writers in ascending unit order; a writer at the common node adds nothing.
            for (int unsigned i = 0; i < UNIT_COUNT; i++)
                if (src[i]) begin
                    n = i;
                    while (n != common) begin
                        add_flush(n, f);
                        n = parent_unit(n);
                    end
                end
            for (int unsigned i = 0; i < UNIT_COUNT; i++)
                if (dst[i]) begin
                    n = i;
                    while (n != common) begin
                        add_invalidate(n, f);
                        n = parent_unit(n);
                    end
                end
            return f;
        endfunction

        function void note_request(unit_mask_t src, unit_mask_t dst);
            pending_flags.push_back(predict_flags(src, dst));
            requests_noted++;
        endfunction

        function string flag_name(int unsigned i);
            case (i)
                0: return "vf_invalidate";
                1: return "cmd_streamer_stall";
                2: return "texture_invalidate";
                3: return "depth_flush";
                4: return "color_flush";
                5: return "data_flush";
                6: return "constant_invalidate";
                7: return "tile_flush";
                8: return "hdc_flush";
                default: return "untyped_flush";
            endcase
        endfunction

        function void check_flags(sync_flags_t got);
            logic [UNIT_COUNT-1:0] want_bits;
            logic [UNIT_COUNT-1:0] got_bits;
            results_checked++;
            if (pending_flags.size() == 0) begin
                $error("result with nothing expected: flags %b", got);
                mismatches++;
                return;
            end
            want_bits = pending_flags.pop_front();
            got_bits  = got;
            for (int unsigned i = 0; i < UNIT_COUNT; i++)
                if (got_bits[i] !== want_bits[i]) begin
                    $error("%s: expected %0b, actual %0b", flag_name(i),
                           want_bits[i], got_bits[i]);
                    mismatches++;
                end
        endfunction
    endclass

    sync_flag_tracker board = new();

    int unsigned idle_cycles = 0;
    int unsigned send_quiet  = 0;
    int unsigned recv_quiet  = 0;
    bit          long_hold_done = 0;

    initial begin
        forever #10 clk = ~clk;
    end

    // Watchdog: a run whose idle count reaches IDLE_LIMIT with no transaction anywhere is hung.
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("cache_sync_flush_resolver test failed");
            $finish;
        end
    end

    function automatic unit_mask_t unit_bit(int unsigned n);
        return unit_mask_t'(1) << n;
    endfunction

    // Mix of empty, sparse and dense masks so that meets at a leaf, at L3
    // and at memory all show up often.
    function automatic unit_mask_t draw_mask();
        int unsigned mode;
        mode = $urandom_range(0, 9);
        if (mode == 0)
            return '0;
        if (mode <= 3)
            return unit_bit($urandom_range(0, UNIT_COUNT - 1));
        if (mode <= 5)
            return unit_bit($urandom_range(0, UNIT_COUNT - 1))
                 | unit_bit($urandom_range(0, UNIT_COUNT - 1));
        return unit_mask_t'($urandom_range(0, 1023));
    endfunction

    // Per-item wait, drawn at random, with occasional runs of back-to-back items.
    function automatic int unsigned draw_gap(ref int unsigned quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0)
            quiet = $urandom_range(20, 60);
        return $urandom_range(0, 17);
    endfunction

    // One input transaction, driven in step with the clock; tvalid stays
    // high across back-to-back items and drops only for a gap before an item.
    task automatic send_request(input unit_mask_t src, input unit_mask_t dst);
        int unsigned gap;
        gap = draw_gap(send_quiet);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_WIDTH - 2 * UNIT_COUNT){1'b0}}, dst, src};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_request(src, dst);
    endtask

    // Register write only with the pipe empty; results always come one per
    // request, so an empty queue plus the pipe depth means idle.
    task automatic write_generation(input logic gen);
        s_axis_tvalid <= 1'b0;
        while (board.pending_flags.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wdata <= gen;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.gen = gen;
    endtask

    // Directed corners: empty masks, full masks, a writer that is its own
    // common node, L3 as a writer with and without earlier flushes, and the
    // vertex fetch unit that moves between hierarchies.
    task automatic run_directed();
        unit_mask_t src_list [13];
        unit_mask_t dst_list [13];
        src_list = '{10'h000, 10'h000, 10'h3FF, 10'h3FF,
                     unit_bit(U_DATA), unit_bit(U_L3),
                     unit_bit(U_DEPTH) | unit_bit(U_RT),
                     unit_bit(U_L3) | unit_bit(U_DEPTH),
                     unit_bit(U_L3), unit_bit(U_DATA),
                     unit_bit(U_DATA) | unit_bit(U_RT),
                     unit_bit(U_VF), unit_bit(U_CPU)};
        dst_list = '{10'h000, 10'h3FF, 10'h000, 10'h3FF,
                     unit_bit(U_DATA), unit_bit(U_DEPTH),
                     unit_bit(U_CPU), unit_bit(U_CS),
                     unit_bit(U_CPU), unit_bit(U_VF),
                     unit_bit(U_CONST) | unit_bit(U_TEX),
                     unit_bit(U_CS) | unit_bit(U_VF), unit_bit(U_MEM)};
        for (int unsigned i = 0; i < 13; i++)
            send_request(src_list[i], dst_list[i]);
    endtask

    task automatic run_random(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            send_request(draw_mask(), draw_mask());
    endtask

    // Result side: random stall before each result, plus one long hold that
    // backs the pipe up until the input side stalls.
    initial begin
        int unsigned stall;
        @(posedge rst_n);
        forever begin
            stall = draw_gap(recv_quiet);
            if (!long_hold_done && board.results_checked >= HOLD_AFTER) begin
                stall          = LONG_HOLD;
                long_hold_done = 1;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            board.check_flags(sync_flags_t'(m_axis_tdata[UNIT_COUNT-1:0]));
        end
    end

    // Main sequence: reset once, then phases alternating the hierarchy.
    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_generation(GEN_OLD);
        run_directed();
        run_random(RANDOM_ITEMS);

        write_generation(GEN_NEW);
        run_directed();
        run_random(RANDOM_ITEMS);

        write_generation(GEN_OLD);
        run_random(RANDOM_ITEMS);

        write_generation(GEN_NEW);
        run_random(RANDOM_ITEMS);

        s_axis_tvalid <= 1'b0;
        while (board.pending_flags.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests over both cache hierarchies, %0d results checked.",
                 board.requests_noted, board.results_checked);
        $display("Random stalls on both sides, one long output hold, %0d mismatches.",
                 board.mismatches);
        if (board.mismatches == 0 && board.pending_flags.size() == 0)
            $display("cache_sync_flush_resolver test passed");
        else
            $display("cache_sync_flush_resolver test failed");
        $finish;
    end

endmodule
